// ===== design/fcf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcf_pkg
// shared types and constants of the contact force pipeline
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int CB    = 21;       // bits per vector component
  localparam int VW    = 3 * CB;   // packed vector width
  localparam int IDW   = 16;
  localparam int CNTW  = 4;
  localparam int CFGW  = 16;
  localparam int AW    = 3;
  localparam int DATAW = 32;

  // register word selects, taken from bit 2 of the byte address
  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_DAMPING   = 1'b1;

  localparam logic [CFGW-1:0] STIFFNESS_RESET = 16'd10000;
  localparam logic [CFGW-1:0] DAMPING_RESET   = 16'd10;

  typedef struct packed {
    logic [IDW-1:0]  body_a_id;
    logic [IDW-1:0]  body_b_id;
    logic [VW-1:0]   point_on_a;
    logic [VW-1:0]   point_on_b;
    logic [VW-1:0]   center_a;
    logic [VW-1:0]   center_b;
    logic [VW-1:0]   linear_vel_a;
    logic [VW-1:0]   angular_vel_a;
    logic [VW-1:0]   linear_vel_b;
    logic [VW-1:0]   angular_vel_b;
    logic [CNTW-1:0] pair_count;
  } in_item_t;

  typedef struct packed {
    logic [IDW-1:0] out_a_id;
    logic [IDW-1:0] out_b_id;
    logic [VW-1:0]  contact_force;
    logic [VW-1:0]  torque_a;
    logic [VW-1:0]  torque_b;
  } out_item_t;

  // one signed component of a packed vector
  function automatic logic signed [CB-1:0] comp(input logic [VW-1:0] w, input int unsigned k);
    return signed'(w[k*CB +: CB]);
  endfunction

endpackage

// ===== design/fcf_sqrt.sv =====
// ----------------------------------------------------------------------------
// fcf_sqrt
// pipelined integer square root, one result bit per stage, with sideband
// ----------------------------------------------------------------------------
module fcf_sqrt #(
  parameter int RW = 22,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*RW-1:0] x,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [PW-1:0]   out_pay
);

  localparam int XW = 2 * RW;

  logic          v   [RW+1];
  logic [XW-1:0] rem [RW+1];
  logic [XW-1:0] res [RW+1];
  logic [PW-1:0] pay [RW+1];

  assign v[0]   = in_valid;
  assign rem[0] = x;
  assign res[0] = '0;
  assign pay[0] = in_pay;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int J = RW - 1 - s;
    logic [XW:0] trial;
    logic        ge;

    always_comb begin
      trial = {1'b0, res[s]} + ((XW+1)'(1) << (2 * J));
      ge    = {1'b0, rem[s]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      pay[s+1] <= pay[s];
      if (ge) begin
        rem[s+1] <= XW'({1'b0, rem[s]} - trial);
        res[s+1] <= (res[s] >> 1) + (XW'(1) << (2 * J));
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= res[s] >> 1;
      end
    end
  end

  assign out_valid = v[RW];
  assign root      = res[RW][RW-1:0];
  assign out_pay   = pay[RW];

endmodule

// ===== design/fcf_div.sv =====
// ----------------------------------------------------------------------------
// fcf_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module fcf_div #(
  parameter int NW = 32,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] out_pay
);

  // quotient must fit in QW bits
  localparam int TW = NW + DW + QW;

  logic          v   [QW+1];
  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dn  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [PW-1:0] pay [QW+1];

  assign v[0]   = in_valid;
  assign rem[0] = num;
  assign dn[0]  = den;
  assign q[0]   = '0;
  assign pay[0] = in_pay;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [TW-1:0] shifted;
    logic          ge;

    always_comb begin
      shifted = TW'(dn[s]) << K;
      ge      = TW'(rem[s]) >= shifted;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      dn[s+1]  <= dn[s];
      pay[s+1] <= pay[s];
      if (ge) begin
        rem[s+1] <= NW'(TW'(rem[s]) - shifted);
        q[s+1]   <= q[s] | (QW'(1) << K);
      end else begin
        rem[s+1] <= rem[s];
        q[s+1]   <= q[s];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign out_pay   = pay[QW];

endmodule

// ===== design/frictionless_contact_force.sv =====
// ----------------------------------------------------------------------------
// frictionless_contact_force
// spring-dashpot normal force and torques for one closest-point pair
// ----------------------------------------------------------------------------
// path from accept to done: stages a to d, the root, the direction dividers,
//   stages f to i, the magnitude divider, stages j to l and the result register
// throughput: one transfer per cycle; busy is always low, done pulses once
//   per item in order; depth is set by the bit-per-stage root and dividers
// reset: synchronous rst clears all valid bits and loads the register
//   defaults (stiffness 10000, damping 10); the receiver cannot stall
// ----------------------------------------------------------------------------
module frictionless_contact_force #(
  parameter int FRACTION_BITS = 10,
  parameter int MAX_PAIRS     = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  fcf_pkg::in_item_t               item,
  output logic                            done,
  output fcf_pkg::out_item_t              result,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcf_pkg::AW-1:0]          paddr,
  input  logic [fcf_pkg::DATAW-1:0]       pwdata,
  output logic [fcf_pkg::DATAW-1:0]       prdata,
  output logic                            pready
);
  import fcf_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int DWD  = CB + 1;               // gap, lever arm width
  localparam int PRW  = 2 * CB + 1;           // one cross product term
  localparam int XW   = 2 * CB + 2 - F;       // scaled cross component
  localparam int RVW  = XW + 2;               // relative velocity
  localparam int SQW  = 2 * CB + 2;           // squared gap
  localparam int LW   = CB + 1;               // gap length
  localparam int NQ   = F + 1;                // unit direction magnitude bits
  localparam int NNW  = CB + F + 1;           // direction numerator
  localparam int NW   = F + 2;                // signed direction component
  localparam int NPW  = NW + RVW;             // n * rv
  localparam int DOTW = NPW + 2;
  localparam int RELW = DOTW - F;
  localparam int SPW  = 2 * LW - F + CFGW;    // spring term, unsigned
  localparam int DMW  = RELW + CFGW + 1;      // damping term, signed
  localparam int MW   = (SPW + 1 > DMW ? SPW + 1 : DMW) + 1;
  localparam int MQW  = CB + $clog2(MAX_PAIRS) + 1;
  localparam int CDW  = $clog2(MAX_PAIRS + 1);
  localparam int CCW  = CDW > CNTW ? CDW : CNTW;
  localparam int MFW  = CB + 2;               // clamped magnitude, signed
  localparam int FPW  = MFW + NW;
  localparam int TPW  = DWD + CB;             // torque product term
  localparam int SATW = 2 * CB + 4 + F + NW;  // widest value fed to saturation
  localparam longint CAP = (64'sd1 <<< CB) * MAX_PAIRS;

  typedef logic signed [DWD-1:0] dvec_t [3];

  typedef struct packed {
    logic [IDW-1:0]              a_id;
    logic [IDW-1:0]              b_id;
    logic [CNTW-1:0]             cnt;
    logic [2:0][DWD-1:0]         d;
    logic [2:0][DWD-1:0]         oa;
    logic [2:0][DWD-1:0]         nob;
    logic [2:0][RVW-1:0]         rv;
  } sq_pay_t;

  typedef struct packed {
    sq_pay_t         sp;
    logic [LW-1:0]   l;
    logic            sgn;
  } nd_pay_t;

  typedef struct packed {
    logic [IDW-1:0]      a_id;
    logic [IDW-1:0]      b_id;
    logic [2:0][DWD-1:0] oa;
    logic [2:0][DWD-1:0] nob;
    logic [2:0][NW-1:0]  n;
    logic                zero;
    logic                neg;
  } md_pay_t;

  function automatic logic [CB-1:0] sat_c(input logic signed [SATW-1:0] x);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'((64'sd1 <<< (CB - 1)) - 1);
    lo = -SATW'(64'sd1 <<< (CB - 1));
    if (x > hi) begin
      return hi[CB-1:0];
    end else if (x < lo) begin
      return lo[CB-1:0];
    end
    return x[CB-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // configuration registers, written on the apb access cycle
  // -------------------------------------------------------------------------
  logic [CFGW-1:0] stiffness;
  logic [CFGW-1:0] damping;
  logic            reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      damping   <= DAMPING_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_STIFFNESS: stiffness <= pwdata[CFGW-1:0];
        REG_DAMPING:   damping   <= pwdata[CFGW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STIFFNESS: prdata = DATAW'(stiffness);
      REG_DAMPING:   prdata = DATAW'(damping);
      default:       prdata = '0;
    endcase
  end

  // the pipeline never holds off a transfer
  assign busy = 1'b0;

  // -------------------------------------------------------------------------
  // stage a: capture the item
  // -------------------------------------------------------------------------
  logic     a_v;
  in_item_t a_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
    a_item <= item;
  end

  // -------------------------------------------------------------------------
  // stage b: midpoint, lever arms and gap vector
  // -------------------------------------------------------------------------
  logic                  b_v;
  logic [IDW-1:0]        b_a_id, b_b_id;
  logic [CNTW-1:0]       b_cnt;
  dvec_t                 b_d, b_oa, b_ob;
  logic signed [CB-1:0]  b_wa [3], b_wb [3], b_la [3], b_lb [3];

  always_ff @(posedge clk) begin
    logic signed [CB:0] psum;
    logic signed [CB:0] mid;
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
    b_a_id <= a_item.body_a_id;
    b_b_id <= a_item.body_b_id;
    b_cnt  <= a_item.pair_count;
    for (int k = 0; k < 3; k++) begin
      psum    = (CB+1)'(comp(a_item.point_on_a, k)) + (CB+1)'(comp(a_item.point_on_b, k));
      mid     = psum >>> 1;
      b_oa[k] <= mid - DWD'(comp(a_item.center_a, k));
      b_ob[k] <= mid - DWD'(comp(a_item.center_b, k));
      b_d[k]  <= DWD'(comp(a_item.point_on_b, k)) - DWD'(comp(a_item.point_on_a, k));
      b_wa[k] <= comp(a_item.angular_vel_a, k);
      b_wb[k] <= comp(a_item.angular_vel_b, k);
      b_la[k] <= comp(a_item.linear_vel_a, k);
      b_lb[k] <= comp(a_item.linear_vel_b, k);
    end
  end

  // -------------------------------------------------------------------------
  // stage c: gap squares and angular cross products
  // -------------------------------------------------------------------------
  logic                  c_v;
  logic [IDW-1:0]        c_a_id, c_b_id;
  logic [CNTW-1:0]       c_cnt;
  dvec_t                 c_d, c_oa, c_ob;
  logic signed [CB-1:0]  c_la [3], c_lb [3];
  logic [2*DWD-2:0]      c_sq [3];
  logic signed [PRW-1:0] c_xa [6], c_xb [6];   // pairs of terms per component

  always_ff @(posedge clk) begin
    logic signed [2*DWD-1:0] sqp;
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b_v;
    end
    c_a_id <= b_a_id;
    c_b_id <= b_b_id;
    c_cnt  <= b_cnt;
    c_d    <= b_d;
    c_oa   <= b_oa;
    c_ob   <= b_ob;
    c_la   <= b_la;
    c_lb   <= b_lb;
    for (int k = 0; k < 3; k++) begin
      sqp     = b_d[k] * b_d[k];
      c_sq[k] <= sqp[2*DWD-2:0];
      // w x o, component k = w[k+1]*o[k+2] - w[k+2]*o[k+1]
      c_xa[2*k]   <= PRW'(b_wa[(k+1)%3] * b_oa[(k+2)%3]);
      c_xa[2*k+1] <= PRW'(b_wa[(k+2)%3] * b_oa[(k+1)%3]);
      c_xb[2*k]   <= PRW'(b_wb[(k+1)%3] * b_ob[(k+2)%3]);
      c_xb[2*k+1] <= PRW'(b_wb[(k+2)%3] * b_ob[(k+1)%3]);
    end
  end

  // -------------------------------------------------------------------------
  // stage d: squared length and relative point velocity
  // -------------------------------------------------------------------------
  logic          d_v;
  logic [SQW-1:0] d_sq;
  sq_pay_t       d_pay;

  always_ff @(posedge clk) begin
    logic signed [PRW:0]   xdif;
    logic signed [XW-1:0]  xa, xb;
    logic signed [XW:0]    va, vb;
    if (rst) begin
      d_v <= 1'b0;
    end else begin
      d_v <= c_v;
    end
    d_sq <= SQW'(c_sq[0]) + SQW'(c_sq[1]) + SQW'(c_sq[2]);
    d_pay.a_id <= c_a_id;
    d_pay.b_id <= c_b_id;
    d_pay.cnt  <= c_cnt;
    for (int k = 0; k < 3; k++) begin
      xdif = (PRW+1)'(c_xa[2*k]) - (PRW+1)'(c_xa[2*k+1]);
      xa   = XW'(xdif >>> F);
      xdif = (PRW+1)'(c_xb[2*k]) - (PRW+1)'(c_xb[2*k+1]);
      xb   = XW'(xdif >>> F);
      va   = (XW+1)'(c_la[k]) + (XW+1)'(xa);
      vb   = (XW+1)'(c_lb[k]) + (XW+1)'(xb);
      d_pay.rv[k]  <= RVW'(vb) - RVW'(va);
      d_pay.d[k]   <= c_d[k];
      d_pay.oa[k]  <= c_oa[k];
      d_pay.nob[k] <= -c_ob[k];
    end
  end

  // -------------------------------------------------------------------------
  // gap length
  // -------------------------------------------------------------------------
  logic          e_v;
  logic [LW-1:0] e_l;
  sq_pay_t       e_pay;

  fcf_sqrt #(.RW(LW), .PW($bits(sq_pay_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_v),
    .x         (d_sq),
    .in_pay    (d_pay),
    .out_valid (e_v),
    .root      (e_l),
    .out_pay   (e_pay)
  );

  // -------------------------------------------------------------------------
  // unit direction, three dividers side by side; lane 0 carries the sideband
  // -------------------------------------------------------------------------
  logic [NNW-1:0] nd_num [3];
  logic [LW-1:0]  nd_den;
  logic [NQ-1:0]  nd_q [3];
  logic           nd_v;
  nd_pay_t        nd_in_pay, nd_out_pay;
  logic           nd_sgn1, nd_sgn2;
  logic           nd_v1, nd_v2;

  always_comb begin
    logic signed [DWD-1:0] dk;
    logic [DWD-1:0]        mag;
    for (int k = 0; k < 3; k++) begin
      dk        = signed'(e_pay.d[k]);
      mag       = dk[DWD-1] ? DWD'(-dk) : DWD'(dk);
      nd_num[k] = NNW'(mag) << F;
    end
    // zero gap: any divisor will do, the result is forced to zero
    nd_den           = (e_l == '0) ? LW'(1) : e_l;
    nd_in_pay.sp     = e_pay;
    nd_in_pay.l      = e_l;
    nd_in_pay.sgn    = e_pay.d[0][DWD-1];
  end

  fcf_div #(.NW(NNW), .DW(LW), .QW(NQ), .PW($bits(nd_pay_t))) u_ndiv0 (
    .clk (clk), .rst (rst), .in_valid (e_v), .num (nd_num[0]), .den (nd_den),
    .in_pay (nd_in_pay), .out_valid (nd_v), .quo (nd_q[0]), .out_pay (nd_out_pay)
  );

  fcf_div #(.NW(NNW), .DW(LW), .QW(NQ), .PW(1)) u_ndiv1 (
    .clk (clk), .rst (rst), .in_valid (e_v), .num (nd_num[1]), .den (nd_den),
    .in_pay (e_pay.d[1][DWD-1]), .out_valid (nd_v1), .quo (nd_q[1]), .out_pay (nd_sgn1)
  );

  fcf_div #(.NW(NNW), .DW(LW), .QW(NQ), .PW(1)) u_ndiv2 (
    .clk (clk), .rst (rst), .in_valid (e_v), .num (nd_num[2]), .den (nd_den),
    .in_pay (e_pay.d[2][DWD-1]), .out_valid (nd_v2), .quo (nd_q[2]), .out_pay (nd_sgn2)
  );

  // -------------------------------------------------------------------------
  // stage f: signed direction, n * rv terms and l*l
  // -------------------------------------------------------------------------
  logic                  f_v;
  logic signed [NW-1:0]  f_n [3];
  logic signed [NPW-1:0] f_np [3];
  logic [2*LW-1:0]       f_ll;
  logic [CNTW-1:0]       f_cnt;
  logic                  f_zero;
  logic [IDW-1:0]        f_a_id, f_b_id;
  logic [2:0][DWD-1:0]   f_oa, f_nob;

  always_ff @(posedge clk) begin
    logic                 sg;
    logic signed [NW-1:0] nk;
    if (rst) begin
      f_v <= 1'b0;
    end else begin
      f_v <= nd_v && nd_v1 && nd_v2;
    end
    for (int k = 0; k < 3; k++) begin
      sg = (k == 0) ? nd_out_pay.sgn : ((k == 1) ? nd_sgn1 : nd_sgn2);
      nk = sg ? -NW'(nd_q[k]) : NW'(nd_q[k]);
      f_n[k]  <= nk;
      f_np[k] <= NPW'(nk * signed'(nd_out_pay.sp.rv[k]));
    end
    f_ll   <= nd_out_pay.l * nd_out_pay.l;
    f_cnt  <= nd_out_pay.sp.cnt;
    f_zero <= nd_out_pay.l == '0;
    f_a_id <= nd_out_pay.sp.a_id;
    f_b_id <= nd_out_pay.sp.b_id;
    f_oa   <= nd_out_pay.sp.oa;
    f_nob  <= nd_out_pay.sp.nob;
  end

  // -------------------------------------------------------------------------
  // stage g: normal velocity dot product, spring term
  // -------------------------------------------------------------------------
  logic                   g_v;
  logic signed [DOTW-1:0] g_dot;
  logic [SPW-1:0]         g_spring;
  logic signed [NW-1:0]   g_n [3];
  logic [CNTW-1:0]        g_cnt;
  logic                   g_zero;
  logic [IDW-1:0]         g_a_id, g_b_id;
  logic [2:0][DWD-1:0]    g_oa, g_nob;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else begin
      g_v <= f_v;
    end
    g_dot    <= DOTW'(f_np[0]) + DOTW'(f_np[1]) + DOTW'(f_np[2]);
    g_spring <= SPW'(f_ll[2*LW-1:F] * stiffness);
    g_n      <= f_n;
    g_cnt    <= f_cnt;
    g_zero   <= f_zero;
    g_a_id   <= f_a_id;
    g_b_id   <= f_b_id;
    g_oa     <= f_oa;
    g_nob    <= f_nob;
  end

  // -------------------------------------------------------------------------
  // stage h: damping term
  // -------------------------------------------------------------------------
  logic                  h_v;
  logic [SPW-1:0]        h_spring;
  logic signed [DMW-1:0] h_damp;
  logic signed [NW-1:0]  h_n [3];
  logic [CNTW-1:0]       h_cnt;
  logic                  h_zero;
  logic [IDW-1:0]        h_a_id, h_b_id;
  logic [2:0][DWD-1:0]   h_oa, h_nob;

  always_ff @(posedge clk) begin
    logic signed [RELW-1:0] rel;
    if (rst) begin
      h_v <= 1'b0;
    end else begin
      h_v <= g_v;
    end
    rel      = RELW'(g_dot >>> F);
    h_damp   <= DMW'(rel * signed'({1'b0, damping}));
    h_spring <= g_spring;
    h_n      <= g_n;
    h_cnt    <= g_cnt;
    h_zero   <= g_zero;
    h_a_id   <= g_a_id;
    h_b_id   <= g_b_id;
    h_oa     <= g_oa;
    h_nob    <= g_nob;
  end

  // -------------------------------------------------------------------------
  // stage i: magnitude, sign and cap, divisor clamp
  // -------------------------------------------------------------------------
  logic           i_v;
  logic [MQW-1:0] i_abs;
  logic [CDW-1:0] i_cnt;
  md_pay_t        i_pay;

  always_ff @(posedge clk) begin
    logic signed [MW-1:0] mag;
    logic [MW-1:0]        am;
    logic [CCW-1:0]       cw;
    if (rst) begin
      i_v <= 1'b0;
    end else begin
      i_v <= h_v;
    end
    mag = signed'(MW'(h_spring)) + MW'(h_damp);
    am  = mag[MW-1] ? MW'(-mag) : MW'(mag);
    // past the cap every divisor still saturates the quotient
    i_abs <= (am > MW'(CAP)) ? MQW'(CAP) : MQW'(am);
    cw = CCW'(h_cnt);
    if (cw == '0) begin
      cw = CCW'(1);
    end else if (cw > CCW'(MAX_PAIRS)) begin
      cw = CCW'(MAX_PAIRS);
    end
    i_cnt <= CDW'(cw);
    i_pay.a_id <= h_a_id;
    i_pay.b_id <= h_b_id;
    i_pay.oa   <= h_oa;
    i_pay.nob  <= h_nob;
    for (int k = 0; k < 3; k++) begin
      i_pay.n[k] <= h_n[k];
    end
    i_pay.zero <= h_zero;
    i_pay.neg  <= mag[MW-1];
  end

  // -------------------------------------------------------------------------
  // force magnitude shared over the pairs of the contact
  // -------------------------------------------------------------------------
  logic           md_v;
  logic [MQW-1:0] md_q;
  md_pay_t        md_pay;

  fcf_div #(.NW(MQW), .DW(CDW), .QW(MQW), .PW($bits(md_pay_t))) u_mdiv (
    .clk (clk), .rst (rst), .in_valid (i_v), .num (i_abs), .den (i_cnt),
    .in_pay (i_pay), .out_valid (md_v), .quo (md_q), .out_pay (md_pay)
  );

  // -------------------------------------------------------------------------
  // stage j: clamp magnitude, scale direction
  // -------------------------------------------------------------------------
  logic                  j_v;
  logic signed [FPW-1:0] j_fp [3];
  md_pay_t               j_pay;

  always_ff @(posedge clk) begin
    logic [MQW-1:0]        qc;
    logic signed [MFW-1:0] m;
    if (rst) begin
      j_v <= 1'b0;
    end else begin
      j_v <= md_v;
    end
    qc = (md_q > (MQW'(1) << CB)) ? (MQW'(1) << CB) : md_q;
    m  = md_pay.neg ? -MFW'(qc) : MFW'(qc);
    for (int k = 0; k < 3; k++) begin
      j_fp[k] <= FPW'(m * signed'(md_pay.n[k]));
    end
    j_pay <= md_pay;
  end

  // -------------------------------------------------------------------------
  // stage k: saturated force
  // -------------------------------------------------------------------------
  logic                 k_v;
  logic signed [CB-1:0] k_f [3];
  md_pay_t              k_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else begin
      k_v <= j_v;
    end
    for (int k = 0; k < 3; k++) begin
      k_f[k] <= signed'(sat_c(SATW'(j_fp[k] >>> F)));
    end
    k_pay <= j_pay;
  end

  // -------------------------------------------------------------------------
  // stage l: torque cross product terms
  // -------------------------------------------------------------------------
  logic                  l_v;
  logic signed [TPW-1:0] l_ta [6], l_tb [6];
  logic signed [CB-1:0]  l_f [3];
  logic                  l_zero;
  logic [IDW-1:0]        l_a_id, l_b_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else begin
      l_v <= k_v;
    end
    for (int k = 0; k < 3; k++) begin
      l_ta[2*k]   <= TPW'(signed'(k_pay.oa[(k+1)%3]) * k_f[(k+2)%3]);
      l_ta[2*k+1] <= TPW'(signed'(k_pay.oa[(k+2)%3]) * k_f[(k+1)%3]);
      l_tb[2*k]   <= TPW'(signed'(k_pay.nob[(k+1)%3]) * k_f[(k+2)%3]);
      l_tb[2*k+1] <= TPW'(signed'(k_pay.nob[(k+2)%3]) * k_f[(k+1)%3]);
    end
    l_f    <= k_f;
    l_zero <= k_pay.zero;
    l_a_id <= k_pay.a_id;
    l_b_id <= k_pay.b_id;
  end

  // -------------------------------------------------------------------------
  // stage m: torques, zero-gap gating, result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    logic signed [TPW:0] dif;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l_v;
    end
    result.out_a_id <= l_a_id;
    result.out_b_id <= l_b_id;
    for (int k = 0; k < 3; k++) begin
      dif = (TPW+1)'(l_ta[2*k]) - (TPW+1)'(l_ta[2*k+1]);
      result.torque_a[k*CB +: CB]      <= l_zero ? '0 : sat_c(SATW'(dif >>> F));
      dif = (TPW+1)'(l_tb[2*k]) - (TPW+1)'(l_tb[2*k+1]);
      result.torque_b[k*CB +: CB]      <= l_zero ? '0 : sat_c(SATW'(dif >>> F));
      result.contact_force[k*CB +: CB] <= l_zero ? '0 : l_f[k];
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the contact force pipeline against a bit-accurate predictor: directed
// corner items, register sweeps and random contact pairs with random gaps
// ----------------------------------------------------------------------------
module tb;
  import fcf_pkg::*;

  localparam int FB = 10;
  localparam int MAXP = 8;
  localparam int DRAIN = 120;   // drain wait, longer than the block's pipeline

  typedef logic signed [63:0] s64_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            item = '0;
  logic                done;
  out_item_t           result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AW-1:0]       paddr = '0;
  logic [DATAW-1:0]    pwdata = '0;
  logic [DATAW-1:0]    prdata;
  logic                pready;

  // predictor copy of the two registers
  logic [15:0]         stiff_q;
  logic [15:0]         damp_q;

  out_item_t           expected_q[$];
  int                  errors = 0;

  frictionless_contact_force dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // timeout guard
  initial begin
    #20000000;
    $display("** frictionless_contact_force: FAILED **");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic s64_t floor_shift(s64_t v, int s);
    return v >>> s;   // arithmetic shift rounds toward minus infinity
  endfunction

  function automatic s64_t clip(s64_t v);
    s64_t hi, lo;
    hi = (64'sd1 <<< (CB - 1)) - 1;
    lo = -(64'sd1 <<< (CB - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic s64_t part(logic [VW-1:0] w, int k);
    logic signed [CB-1:0] c;
    c = w[k*CB +: CB];
    return s64_t'(c);
  endfunction

  function automatic logic [VW-1:0] pack_clip(s64_t x, s64_t y, s64_t z);
    logic [VW-1:0] w;
    s64_t cx, cy, cz;
    cx = clip(x); cy = clip(y); cz = clip(z);
    w = {cz[CB-1:0], cy[CB-1:0], cx[CB-1:0]};
    return w;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // cross product a x b rescaled, into r[0..2]
  task automatic cross_fix(input s64_t a[3], input s64_t b[3], output s64_t r[3]);
    r[0] = floor_shift(a[1] * b[2] - a[2] * b[1], FB);
    r[1] = floor_shift(a[2] * b[0] - a[0] * b[2], FB);
    r[2] = floor_shift(a[0] * b[1] - a[1] * b[0], FB);
  endtask

  task automatic predict_force(input in_item_t it, output out_item_t o);
    s64_t pa[3], pb[3], ca[3], cb[3], la[3], wa[3], lb[3], wb[3];
    s64_t oa[3], ob[3], d[3], n[3], f[3], ta[3], tb[3], xa[3], xb[3], nob[3];
    s64_t cnt, dot, rel, mag, lim, p;
    logic [63:0] sq, l;
    for (int k = 0; k < 3; k++) begin
      pa[k] = part(it.point_on_a, k);   pb[k] = part(it.point_on_b, k);
      ca[k] = part(it.center_a, k);     cb[k] = part(it.center_b, k);
      la[k] = part(it.linear_vel_a, k); wa[k] = part(it.angular_vel_a, k);
      lb[k] = part(it.linear_vel_b, k); wb[k] = part(it.angular_vel_b, k);
    end
    cnt = it.pair_count;
    if (cnt < 1) cnt = 1;
    if (cnt > MAXP) cnt = MAXP;
    o = '0;
    o.out_a_id = it.body_a_id;
    o.out_b_id = it.body_b_id;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      p = floor_shift(pa[k] + pb[k], 1);
      oa[k] = p - ca[k];
      ob[k] = p - cb[k];
      d[k] = pb[k] - pa[k];
      sq = sq + 64'(d[k] * d[k]);
    end
    l = int_sqrt(sq);
    if (l == 0) return;   // zero gap: no force, no torque
    for (int k = 0; k < 3; k++) n[k] = (d[k] * (64'sd1 <<< FB)) / s64_t'(l);
    cross_fix(wa, oa, xa);
    cross_fix(wb, ob, xb);
    dot = 0;
    for (int k = 0; k < 3; k++)
      dot = dot + n[k] * ((lb[k] + xb[k]) - (la[k] + xa[k]));
    rel = floor_shift(dot, FB);
    mag = floor_shift(s64_t'(l * l), FB) * s64_t'({48'd0, stiff_q})
        + rel * s64_t'({48'd0, damp_q});
    mag = mag / cnt;
    lim = 64'sd1 <<< CB;
    if (mag > lim) mag = lim;
    if (mag < -lim) mag = -lim;
    for (int k = 0; k < 3; k++) f[k] = clip(floor_shift(mag * n[k], FB));
    cross_fix(oa, f, ta);
    for (int k = 0; k < 3; k++) nob[k] = -ob[k];
    cross_fix(nob, f, tb);
    o.contact_force = pack_clip(f[0], f[1], f[2]);
    o.torque_a = pack_clip(ta[0], ta[1], ta[2]);
    o.torque_b = pack_clip(tb[0], tb[1], tb[2]);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.out_a_id !== e.out_a_id) begin
          $display("%0t out_a_id exp %h got %h", $time, e.out_a_id, result.out_a_id);
          errors++;
        end
        if (result.out_b_id !== e.out_b_id) begin
          $display("%0t out_b_id exp %h got %h", $time, e.out_b_id, result.out_b_id);
          errors++;
        end
        if (result.contact_force !== e.contact_force) begin
          $display("%0t contact_force exp %h got %h", $time, e.contact_force,
                   result.contact_force);
          errors++;
        end
        if (result.torque_a !== e.torque_a) begin
          $display("%0t torque_a exp %h got %h", $time, e.torque_a, result.torque_a);
          errors++;
        end
        if (result.torque_b !== e.torque_b) begin
          $display("%0t torque_b exp %h got %h", $time, e.torque_b, result.torque_b);
          errors++;
        end
      end
    end
  end

  // ---------------- drivers ----------------
  // idle cycles after a transfer: mostly none, otherwise short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // one item transfer; start stays high across back-to-back items
  task automatic send_item(input in_item_t it, input bit gaps);
    out_item_t e;
    int n;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_force(it, e);
    expected_q.push_back(e);
    n = (gaps && $urandom_range(0, 1)) ? gap_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      item <= '0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic end_items();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AW'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == 0) stiff_q = val[15:0];
    else if (idx == 1) damp_q = val[15:0];
    @(posedge clk);
  endtask

  function automatic logic [VW-1:0] rand_vec();
    return VW'({$urandom(), $urandom()});
  endfunction

  // vector with small components around a base, to keep gaps physical
  function automatic logic [VW-1:0] near_vec(logic [VW-1:0] base, int span);
    logic [VW-1:0] w;
    s64_t c;
    for (int k = 0; k < 3; k++) begin
      c = part(base, k) + $signed($urandom_range(0, 2 * span)) - span;
      w[k*CB +: CB] = c[CB-1:0];
    end
    return w;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int mode;
    it = '0;
    it.body_a_id = IDW'($urandom()); it.body_b_id = IDW'($urandom());
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      it.point_on_a = near_vec(rand_vec() >> ($urandom_range(0, 2) * 4), 4000);
      it.point_on_b = near_vec(it.point_on_a, $urandom_range(0, 1) ? 8 : 2000);
      it.center_a = near_vec(it.point_on_a, 5000);
      it.center_b = near_vec(it.point_on_b, 5000);
      it.linear_vel_a = near_vec('0, 4000);
      it.linear_vel_b = near_vec('0, 4000);
      it.angular_vel_a = near_vec('0, 2000);
      it.angular_vel_b = near_vec('0, 2000);
    end else begin
      it.point_on_a = rand_vec(); it.point_on_b = rand_vec();
      it.center_a = rand_vec(); it.center_b = rand_vec();
      it.linear_vel_a = rand_vec(); it.linear_vel_b = rand_vec();
      it.angular_vel_a = rand_vec(); it.angular_vel_b = rand_vec();
      if (mode == 9) it.point_on_b = it.point_on_a;   // zero gap
    end
    it.pair_count = ($urandom_range(0, 9) == 0) ? CNTW'($urandom())
                                                : CNTW'($urandom_range(1, 8));
    return it;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    in_item_t it;
    logic [VW-1:0] ones, maxv, minv;
    ones = '1;
    maxv = {3{1'b0, {(CB-1){1'b1}}}};
    minv = {3{1'b1, {(CB-1){1'b0}}}};
    // zero gap with all zero inputs
    send_item('0, 0);
    it = '1;   // every bit set, zero gap
    send_item(it, 0);
    // extreme opposite corners, each pair count code
    for (int c = 0; c < 16; c++) begin
      it = '0;
      it.body_a_id = (c & 1) ? 16'hFFFF : 16'h0000;
      it.body_b_id = ~it.body_a_id;
      it.point_on_a = (c & 2) ? minv : maxv;
      it.point_on_b = (c & 2) ? maxv : minv;
      it.center_a = (c & 4) ? maxv : minv;
      it.center_b = (c & 4) ? minv : maxv;
      it.linear_vel_a = (c & 8) ? maxv : minv;
      it.linear_vel_b = (c & 8) ? minv : maxv;
      it.angular_vel_a = (c & 1) ? maxv : ones;
      it.angular_vel_b = (c & 1) ? minv : ones;
      it.pair_count = c[3:0];
      send_item(it, 0);
    end
    // unit gap along x, small values
    it = '0;
    it.point_on_b = 63'd1024;
    it.pair_count = 4'd1;
    send_item(it, 0);
    end_items();
    wait_drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item(), 1);
    end_items();
    wait_drain();
  endtask

  task automatic test_registers();
    logic [15:0] vals[5];
    vals[0] = 16'd0; vals[1] = 16'hFFFF; vals[2] = 16'd1;
    vals[3] = 16'd10000; vals[4] = 16'd10;
    for (int s = 0; s < 5; s++) begin
      reg_write(0, {16'($urandom_range(0, 65535)), vals[s]});
      reg_write(1, {16'hA5A5, vals[4 - s]});
      test_random(30);
    end
    reg_write(0, $urandom_range(0, 65535));
    reg_write(1, $urandom_range(0, 65535));
  endtask

  initial begin
    stiff_q = STIFFNESS_RESET;
    damp_q = DAMPING_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random(220);   // main random run, including the pause to drain
    test_random(220);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** frictionless_contact_force: PASSED **");
    end else begin
      $display("** frictionless_contact_force: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcf_pkg.sv
design/fcf_sqrt.sv
design/fcf_div.sv
design/frictionless_contact_force.sv
tb/tb.sv
